FILE: rtl/thc_pkg.sv
// shared types, constants and helpers for the texture handle cache
package thc_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int KEY_W = 58;
	localparam int HANDLE_W = 16;
	localparam int ENTRY_W = KEY_W + HANDLE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [HANDLE_W-1:0] NO_HANDLE = '1;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] src_address;
		logic [10:0] tex_width;
		logic [10:0] tex_height;
		logic [3:0]  tex_format;
		logic [15:0] new_handle;
	} in_word_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] found_handle;
		logic        evicted;
		logic [15:0] evicted_handle;
	} out_word_t;

	typedef struct packed {
		logic                rd_en;
		logic [IDX_W-1:0]    rd_addr;
		logic                wr_en;
		logic [IDX_W-1:0]    wr_addr;
		logic [KEY_W-1:0]    wr_key;
		logic [HANDLE_W-1:0] wr_handle;
	} mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INS_RD,
		ST_INS_WR
	} state_t;

	function automatic logic [KEY_W-1:0] make_key(input in_word_t w);
		make_key = {w.src_address, w.tex_width, w.tex_height, w.tex_format};
	endfunction

endpackage

FILE: rtl/thc_store.sv
// key and handle storage, one write port and one registered read port
module thc_store (
	input  logic                          clk,
	input  thc_pkg::mem_req_t             req,
	output logic [thc_pkg::KEY_W-1:0]     rd_key,
	output logic [thc_pkg::HANDLE_W-1:0]  rd_handle
);

	logic [thc_pkg::ENTRY_W-1:0] mem_q [thc_pkg::ENTRIES];
	logic [thc_pkg::ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= {req.wr_key, req.wr_handle};
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_key    = rd_data_q[thc_pkg::ENTRY_W-1:thc_pkg::HANDLE_W];
	assign rd_handle = rd_data_q[thc_pkg::HANDLE_W-1:0];

endmodule

FILE: rtl/thc_seq.sv
// sequencer with the shared key comparator, valid bits and insert pointer
module thc_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  thc_pkg::in_word_t             cmd,
	output logic                          busy,
	output logic                          done,
	output thc_pkg::out_word_t            rsp,
	output thc_pkg::mem_req_t             mem_req,
	input  logic [thc_pkg::KEY_W-1:0]     rd_key,
	input  logic [thc_pkg::HANDLE_W-1:0]  rd_handle
);

	thc_pkg::state_t state_q, state_d;

	logic [thc_pkg::KEY_W-1:0]    key_q;
	logic [thc_pkg::HANDLE_W-1:0] handle_q;
	logic [thc_pkg::IDX_W-1:0]    ptr_q;
	logic [thc_pkg::IDX_W-1:0]    scan_q;
	logic [thc_pkg::IDX_W-1:0]    cmp_idx_q;
	logic                         cmp_pend_q;
	logic [thc_pkg::ENTRIES-1:0]  valid_q;
	logic                         done_q;
	thc_pkg::out_word_t           rsp_q;

	logic               accept;
	logic               match;
	logic               res_en;
	thc_pkg::out_word_t res_d;

	assign accept = start && (state_q == thc_pkg::ST_IDLE);
	assign match  = cmp_pend_q && valid_q[cmp_idx_q] && (rd_key == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			thc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (cmd.kind == thc_pkg::KIND_INSERT) ? thc_pkg::ST_INS_RD
						: thc_pkg::ST_SCAN;
				end
			end
			thc_pkg::ST_SCAN: begin
				if (match || (cmp_pend_q && cmp_idx_q == thc_pkg::LAST_IDX)) begin
					state_d = thc_pkg::ST_IDLE;
				end
			end
			thc_pkg::ST_INS_RD: state_d = thc_pkg::ST_INS_WR;
			thc_pkg::ST_INS_WR: state_d = thc_pkg::ST_IDLE;
			default:            state_d = thc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_req           = '0;
		mem_req.wr_addr   = ptr_q;
		mem_req.wr_key    = key_q;
		mem_req.wr_handle = handle_q;
		res_en            = 1'b0;
		res_d.hit            = 1'b0;
		res_d.found_handle   = thc_pkg::NO_HANDLE;
		res_d.evicted        = 1'b0;
		res_d.evicted_handle = thc_pkg::NO_HANDLE;
		unique case (state_q)
			thc_pkg::ST_IDLE: begin
			end
			thc_pkg::ST_SCAN: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = scan_q;
				if (match) begin
					res_en             = 1'b1;
					res_d.hit          = 1'b1;
					res_d.found_handle = rd_handle;
				end else if (cmp_pend_q && cmp_idx_q == thc_pkg::LAST_IDX) begin
					res_en = 1'b1;
				end
			end
			thc_pkg::ST_INS_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = ptr_q;
			end
			thc_pkg::ST_INS_WR: begin
				mem_req.wr_en = 1'b1;
				res_en        = 1'b1;
				if (valid_q[ptr_q]) begin
					res_d.evicted        = 1'b1;
					res_d.evicted_handle = rd_handle;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= thc_pkg::ST_IDLE;
			ptr_q      <= '0;
			scan_q     <= '0;
			cmp_idx_q  <= '0;
			cmp_pend_q <= 1'b0;
			valid_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_en;
			if (accept) begin
				scan_q     <= '0;
				cmp_pend_q <= 1'b0;
			end else if (state_q == thc_pkg::ST_SCAN) begin
				cmp_pend_q <= 1'b1;
				cmp_idx_q  <= scan_q;
				if (scan_q != thc_pkg::LAST_IDX) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (state_q == thc_pkg::ST_INS_WR) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == thc_pkg::LAST_IDX) ? '0 : ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= thc_pkg::make_key(cmd);
			handle_q <= cmd.new_handle;
		end
		if (res_en) begin
			rsp_q <= res_d;
		end
	end

	assign busy = (state_q != thc_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/fifo_texture_handle_cache_top.sv
// a lookup reads and compares the entries in order from entry 0 and ends on the first
// valid match or, on a miss, after the last entry; an insert reads the old entry at the
// insert pointer, then writes it; busy is high until the result cycle; one word at a
// time, and the next start is taken in the done cycle
// reset clears all valid marks, the insert pointer and the sequencer at once, no sweep
// results are strobed for one cycle by done; the receiver cannot stall
module fifo_texture_handle_cache_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  thc_pkg::in_word_t   cmd,
	output logic                busy,
	output logic                done,
	output thc_pkg::out_word_t  rsp
);

	thc_pkg::mem_req_t             mem_req;
	logic [thc_pkg::KEY_W-1:0]     rd_key;
	logic [thc_pkg::HANDLE_W-1:0]  rd_handle;

	thc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.rd_key    (rd_key),
		.rd_handle (rd_handle)
	);

	thc_store u_store (
		.clk       (clk),
		.req       (mem_req),
		.rd_key    (rd_key),
		.rd_handle (rd_handle)
	);

endmodule
